### rtl/bgr2yuv_pkg.sv
package bgr2yuv_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COMP_W    = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = CFG_IDX_W'(0),
        CFG_FRAME_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_e;

    // Q16 coefficients, BT.601 studio swing
    localparam int FRAC_W = 16;
    localparam int COEF_W = 18;
    localparam int SUM_W  = 27;

    localparam logic signed [COEF_W-1:0] Y_R  = COEF_W'(16843);
    localparam logic signed [COEF_W-1:0] Y_G  = COEF_W'(33030);
    localparam logic signed [COEF_W-1:0] Y_B  = COEF_W'(6423);
    localparam logic signed [COEF_W-1:0] CB_R = COEF_W'(-9699);
    localparam logic signed [COEF_W-1:0] CB_G = COEF_W'(-19071);
    localparam logic signed [COEF_W-1:0] CB_B = COEF_W'(28770);
    localparam logic signed [COEF_W-1:0] CR_R = COEF_W'(28770);
    localparam logic signed [COEF_W-1:0] CR_G = COEF_W'(-24117);
    localparam logic signed [COEF_W-1:0] CR_B = COEF_W'(-4653);

    localparam logic signed [SUM_W-1:0] Y_OFS   = SUM_W'(16 << FRAC_W);
    localparam logic signed [SUM_W-1:0] C_OFS   = SUM_W'(128 << FRAC_W);
    localparam logic signed [SUM_W-1:0] SAT_LIM = SUM_W'(256 << FRAC_W);

    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic [COMP_W-1:0] chroma_blue;
        logic [COMP_W-1:0] chroma_red;
    } yuv_t;

    typedef struct packed {
        logic chroma_valid;
        logic frame_end;
    } pos_flags_t;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } frame_limits_t;

    function automatic logic signed [SUM_W-1:0] weigh(
        input logic [COMP_W-1:0]        px,
        input logic signed [COEF_W-1:0] c
    );
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] k;
        a = {{(SUM_W-COMP_W){1'b0}}, px};
        k = {{(SUM_W-COEF_W){c[COEF_W-1]}}, c};
        return a * k;
    endfunction

    function automatic logic [COMP_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] s);
        logic [COMP_W-1:0] r;
        if (s < 0)
        begin
            r = '0;
        end
        else if (s >= SAT_LIM)
        begin
            r = '1;
        end
        else
        begin
            r = s[FRAC_W+COMP_W-1:FRAC_W];
        end
        return r;
    endfunction

endpackage

### rtl/bgr2yuv_if.sv
interface bgr2yuv_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [bgr2yuv_pkg::COMP_W-1:0]   blue;
    logic [bgr2yuv_pkg::COMP_W-1:0]   green;
    logic [bgr2yuv_pkg::COMP_W-1:0]   red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface bgr2yuv_result_if;
    logic                             valid;
    logic                             ready;
    logic [bgr2yuv_pkg::COMP_W-1:0]   luma;
    logic [bgr2yuv_pkg::COMP_W-1:0]   chroma_blue;
    logic [bgr2yuv_pkg::COMP_W-1:0]   chroma_red;
    logic                             chroma_valid;
    logic                             frame_end;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    output chroma_valid, output frame_end, input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    input chroma_valid, input frame_end, output ready);
endinterface

interface bgr2yuv_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bgr2yuv_pkg::CFG_IDX_W-1:0]   index;
    logic [bgr2yuv_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bgr2yuv_cfg_regs.sv
module bgr2yuv_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    bgr2yuv_cfg_if.sink                 cfg,
    output bgr2yuv_pkg::frame_limits_t  limits
);
    import bgr2yuv_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg.data;
                CFG_FRAME_HEIGHT: height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // last position index, size saturated to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
        begin
            limits.col_last = '0;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            limits.col_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            limits.col_last = COL_W'(32'(width_reg) - 32'd1);
        end

        if (height_reg == '0)
        begin
            limits.row_last = '0;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            limits.row_last = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            limits.row_last = ROW_W'(32'(height_reg) - 32'd1);
        end
    end

endmodule

### rtl/bgr2yuv_position.sv
module bgr2yuv_position (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  bgr2yuv_pkg::frame_limits_t  limits,
    output bgr2yuv_pkg::pos_flags_t     flags
);
    import bgr2yuv_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             last_col;
    logic             last_row;

    assign last_col = (col_reg >= limits.col_last);
    assign last_row = (row_reg >= limits.row_last);

    assign flags.chroma_valid = ~(col_reg[0] | row_reg[0]);
    assign flags.frame_end    = last_col & last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### rtl/bgr2yuv_csc.sv
module bgr2yuv_csc (
    input  bgr2yuv_pkg::pix_t  pix,
    output bgr2yuv_pkg::yuv_t  yuv
);
    import bgr2yuv_pkg::*;

    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] cb_sum;
    logic signed [SUM_W-1:0] cr_sum;

    assign y_sum  = weigh(pix.red, Y_R) + weigh(pix.green, Y_G)
                  + weigh(pix.blue, Y_B) + Y_OFS;
    assign cb_sum = weigh(pix.red, CB_R) + weigh(pix.green, CB_G)
                  + weigh(pix.blue, CB_B) + C_OFS;
    assign cr_sum = weigh(pix.red, CR_R) + weigh(pix.green, CR_G)
                  + weigh(pix.blue, CR_B) + C_OFS;

    assign yuv.luma        = clamp_q16(y_sum);
    assign yuv.chroma_blue = clamp_q16(cb_sum);
    assign yuv.chroma_red  = clamp_q16(cr_sum);

endmodule

### rtl/bgr2yuv_to_yuv420_pixel_converter.sv
// BGR to BT.601 studio-swing YCbCr 4:2:0 pixel converter, top level.
// A pixel passes the input register, then the result register; the color matrix is
// a single registered pass. Throughput: one pixel per cycle while result.ready is set.
// Reset: rst_n asynchronous, active low; clears pipeline valids and position
// counters, frame size returns to 1920 x 1080. No clearing pass.
module bgr_to_yuv420_pixel_converter (
    input  logic               clk,
    input  logic               rst_n,
    bgr2yuv_pixel_if.sink      pixel,
    bgr2yuv_result_if.source   result,
    bgr2yuv_cfg_if.sink        cfg
);
    import bgr2yuv_pkg::*;

    frame_limits_t limits;
    pos_flags_t    flags;
    pix_t          pix_in;
    yuv_t          yuv;

    logic          s1_valid_reg;
    pix_t          s1_pix_reg;
    pos_flags_t    s1_flags_reg;
    logic          out_valid_reg;
    yuv_t          out_yuv_reg;
    pos_flags_t    out_flags_reg;

    logic          in_fire;
    logic          s2_load;

    assign pix_in.blue  = pixel.blue;
    assign pix_in.green = pixel.green;
    assign pix_in.red   = pixel.red;

    assign s2_load     = s1_valid_reg & (~out_valid_reg | result.ready);
    assign pixel.ready = ~s1_valid_reg | s2_load;
    assign in_fire     = pixel.valid & pixel.ready;

    bgr2yuv_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    bgr2yuv_position u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .limits  (limits),
        .flags   (flags)
    );

    bgr2yuv_csc u_csc (
        .pix (s1_pix_reg),
        .yuv (yuv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire | (s1_valid_reg & ~s2_load);
            out_valid_reg <= s2_load | (out_valid_reg & ~result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= pix_in;
            s1_flags_reg <= flags;
        end
        if (s2_load)
        begin
            out_yuv_reg   <= yuv;
            out_flags_reg <= s1_flags_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.luma         = out_yuv_reg.luma;
    assign result.chroma_blue  = out_yuv_reg.chroma_blue;
    assign result.chroma_red   = out_yuv_reg.chroma_red;
    assign result.chroma_valid = out_flags_reg.chroma_valid;
    assign result.frame_end    = out_flags_reg.frame_end;

    a_in_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted request did not reach the input register");

    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> out_valid_reg)
        else $error("input register moved but no result is pending");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !pixel.ready)
        else $error("request taken while both registers are full and stalled");

endmodule

### tb/yuv_predict_compare.sv
`timescale 1ns / 100ps

module yuv_predict_compare (
    input  logic        clk,
    input  logic        rst_n,
    bgr2yuv_pixel_if    pixel_mon,
    bgr2yuv_result_if   result_mon,
    bgr2yuv_cfg_if      cfg_mon,
    output int          yuv_mismatches,
    output int          pending_results
);
    import bgr2yuv_pkg::*;

    localparam int KY_R  = 16843;
    localparam int KY_G  = 33030;
    localparam int KY_B  = 6423;
    localparam int KCB_R = -9699;
    localparam int KCB_G = -19071;
    localparam int KCB_B = 28770;
    localparam int KCR_R = 28770;
    localparam int KCR_G = -24117;
    localparam int KCR_B = -4653;
    localparam int LUMA_BIAS   = 16 * 65536;
    localparam int CHROMA_BIAS = 128 * 65536;
    localparam int FULL_SCALE  = 256 * 65536;

    typedef struct packed {
        yuv_t       color;
        pos_flags_t flags;
    } yuv_expect_t;

    yuv_expect_t      yuv_expected_q[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;

    function automatic logic [COMP_W-1:0] saturate_q16(input int s);
        logic [COMP_W-1:0] v;
        if (s < 0)
        begin
            v = '0;
        end
        else if (s >= FULL_SCALE)
        begin
            v = '1;
        end
        else
        begin
            v = s[23:16];
        end
        return v;
    endfunction

    function automatic yuv_t convert_pixel(input int r, input int g, input int b);
        yuv_t c;
        c.luma        = saturate_q16(KY_R * r + KY_G * g + KY_B * b + LUMA_BIAS);
        c.chroma_blue = saturate_q16(KCB_R * r + KCB_G * g + KCB_B * b + CHROMA_BIAS);
        c.chroma_red  = saturate_q16(KCR_R * r + KCR_G * g + KCR_B * b + CHROMA_BIAS);
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] usable_size(input logic [CFG_W-1:0] v,
                                                     input int limit);
        logic [CFG_W-1:0] s;
        if (v == '0)
        begin
            s = CFG_W'(1);
        end
        else if (v > CFG_W'(limit))
        begin
            s = CFG_W'(limit);
        end
        else
        begin
            s = v;
        end
        return s;
    endfunction

    task automatic note_field(input string name, input logic [COMP_W-1:0] want,
                              input logic [COMP_W-1:0] got);
        if (want !== got)
        begin
            yuv_mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        yuv_expect_t      e;
        logic [CFG_W-1:0] last_x;
        logic [CFG_W-1:0] last_y;
        logic             at_last_col;
        logic             at_last_row;
        if (!rst_n)
        begin
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            col_pos    = '0;
            row_pos    = '0;
            yuv_expected_q.delete();
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (yuv_expected_q.size() == 0)
                begin
                    yuv_mismatches++;
                    $display("%0t: result expected none actual luma %0d", $time,
                             result_mon.luma);
                end
                else
                begin
                    e = yuv_expected_q.pop_front();
                    note_field("luma", e.color.luma, result_mon.luma);
                    note_field("chroma_blue", e.color.chroma_blue, result_mon.chroma_blue);
                    note_field("chroma_red", e.color.chroma_red, result_mon.chroma_red);
                    note_field("chroma_valid", COMP_W'(e.flags.chroma_valid),
                               COMP_W'(result_mon.chroma_valid));
                    note_field("frame_end", COMP_W'(e.flags.frame_end),
                               COMP_W'(result_mon.frame_end));
                end
            end

            if (pixel_mon.valid && pixel_mon.ready)
            begin
                last_x      = usable_size(width_reg, MAX_WIDTH) - 1'b1;
                last_y      = usable_size(height_reg, MAX_HEIGHT) - 1'b1;
                at_last_col = {1'b0, col_pos} >= last_x;
                at_last_row = {1'b0, row_pos} >= last_y;
                e.color     = convert_pixel(int'(pixel_mon.red), int'(pixel_mon.green),
                                            int'(pixel_mon.blue));
                e.flags.chroma_valid = ~(col_pos[0] | row_pos[0]);
                e.flags.frame_end    = at_last_col && at_last_row;
                yuv_expected_q.push_back(e);
                if (at_last_col)
                begin
                    col_pos = '0;
                    row_pos = at_last_row ? '0 : row_pos + 1'b1;
                end
                else
                begin
                    col_pos = col_pos + 1'b1;
                end
            end

            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == CFG_FRAME_WIDTH)
                begin
                    width_reg = cfg_mon.data;
                end
                else if (cfg_mon.index == CFG_FRAME_HEIGHT)
                begin
                    height_reg = cfg_mon.data;
                end
            end
        end
        pending_results = yuv_expected_q.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bgr2yuv_pkg::*;

    localparam int HOLD_CYCLES  = 64;
    localparam int RUN_LIMIT_NS = 800000;

    logic clk;
    logic rst_n;
    bit   start_long_hold;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   yuv_mismatches;
    int   pending_results;

    bgr2yuv_pixel_if  pixel_bus ();
    bgr2yuv_result_if result_bus ();
    bgr2yuv_cfg_if    cfg_bus ();

    bgr_to_yuv420_pixel_converter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    yuv_predict_compare yuv_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .pixel_mon       (pixel_bus),
        .result_mon      (result_bus),
        .cfg_mon         (cfg_bus),
        .yuv_mismatches  (yuv_mismatches),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (start_long_hold && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (!rst_n)
            begin
                result_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_pixel(input logic [COMP_W-1:0] b, input logic [COMP_W-1:0] g,
                              input logic [COMP_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.blue  <= b;
        pixel_bus.green <= g;
        pixel_bus.red   <= r;
        do @(posedge clk); while (!pixel_bus.ready);
    endtask

    task automatic send_random_pixel();
        logic [COMP_W-1:0] c[3];
        foreach (c[k])
        begin
            if ($urandom_range(7) == 0)
            begin
                c[k] = $urandom_range(1) ? '1 : '0;
            end
            else
            begin
                c[k] = COMP_W'($urandom);
            end
        end
        send_pixel(c[0], c[1], c[2]);
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain_results();
        pixel_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_FRAME_WIDTH;
        cfg_bus.data  <= w;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.index <= CFG_FRAME_HEIGHT;
        cfg_bus.data  <= h;
        do @(posedge clk); while (!cfg_bus.ready);
        if ($urandom_range(1))
        begin
            cfg_bus.index <= CFG_IDX_W'($urandom_range(255, int'(CFG_FRAME_HEIGHT) + 1));
            cfg_bus.data  <= CFG_W'($urandom);
            do @(posedge clk); while (!cfg_bus.ready);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_dimension();
        logic [CFG_W-1:0] d;
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = CFG_W'(2 * $urandom_range(7) + 1);
            2:       d = CFG_W'($urandom_range(8191, MAX_WIDTH));
            default: d = CFG_W'(2 * $urandom_range(8, 1));
        endcase
        return d;
    endfunction

    initial
    begin
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 87, 0, 14};
        stall_mix = '{0, 0, 87, 14};
        start_long_hold = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.blue  <= '0;
        pixel_bus.green <= '0;
        pixel_bus.red   <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.index   <= CFG_FRAME_WIDTH;
        cfg_bus.data    <= '0;
        do @(posedge clk); while (!rst_n);
        @(posedge clk);

        // color extremes at the reset frame size
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        drain_results();

        // shrink in mid-line: column already past the new end
        program_frame(13'd2, 13'd2);
        repeat (4) send_random_pixel();
        drain_results();
        // zero size acts as one pixel per frame
        program_frame(13'd0, 13'd0);
        repeat (2) send_random_pixel();
        drain_results();
        // oversize saturates
        program_frame(13'd8191, 13'd4096);
        repeat (2) send_random_pixel();
        drain_results();
        program_frame(13'd2, 13'd8);
        repeat (7) send_random_pixel();
        drain_results();
        // row past the new last line
        program_frame(13'd2, 13'd2);
        repeat (2) send_random_pixel();
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            for (int half = 0; half < 2; half++)
            begin
                program_frame(random_dimension(), random_dimension());
                for (int i = 0; i < 100; i++)
                begin
                    if (phase == 0 && half == 0 && i == 40)
                    begin
                        start_long_hold <= 1'b1;
                    end
                    send_random_pixel();
                end
                drain_results();
            end
        end

        drain_results();
        if (yuv_mismatches == 0 && pending_results == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
